/* design/cag_pkg.sv */
// ----------------------------------------------------------------------------
// cag_pkg
// Shared types and constants for the cyclic automaton generation block.
// ----------------------------------------------------------------------------
package cag_pkg;

  typedef logic [1:0] color_t;

  // One column of the four-row ring: element i holds ring row i.
  typedef logic [3:0][1:0] ring_word_t;

  localparam color_t COLOR_BLUE  = 2'd0;
  localparam color_t COLOR_WHITE = 2'd1;
  localparam color_t COLOR_RED   = 2'd2;
  localparam color_t COLOR_THREE = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_GRID_WIDTH     = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_FLIP_THRESHOLD = 2'd2;

  localparam logic [14:0] COUNT_LIMIT = 15'd16384;

  // Per-cell neighbourhood controls handed to the rule logic.
  typedef struct packed {
    logic       up_ok;
    logic       down_ok;
    logic       left_ok;
    logic       right_ok;
    logic [1:0] slot;
    logic [3:0] threshold;
  } cell_ctrl_t;

endpackage

/* design/cyclic_automaton_generation.sv */
// ----------------------------------------------------------------------------
// cyclic_automaton_generation
// One generation of a three-colour cyclic automaton over a raster stream.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the cells of a frame in raster order on the s_ channel, one cell
//   per transaction, then grid_width+1 drain transactions (tuser set).
//   Every transaction is accepted, but the first grid_width+1 of a frame
//   yield no result; each later one releases the result of the cell that
//   entered grid_width+1 transactions before. The result for the last cell
//   of the frame carries tlast and the frame's change count ends there.
//   Throughput is one transaction per cycle while s_tready is high.
//   A released result reaches the m_ channel through the column reads
//   of the ring memory and then the result register. Reset clears
//   position, count and the output register, loads the default sizes,
//   and zeroes the ring memory in a sweep over all MAX_WIDTH columns,
//   during which s_tready stays low. Configuration writes are taken at
//   any time. When the receiver stalls, the result register holds, the
//   read stage behind it holds, and s_tready drops once both are full;
//   nothing is dropped.
// ----------------------------------------------------------------------------
module cyclic_automaton_generation import cag_pkg::*; #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [1:0] cell_color
  input  logic [0:0]  s_tuser,   // [0] is_drain
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [1:0] next_color, [2] changed, [17:3] change_count
  output logic        m_tlast    // frame_last
);

  localparam int CPW = $clog2(MAX_WIDTH + 1);              // column position
  localparam int CIW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1; // column address
  localparam int RPW = $clog2(MAX_HEIGHT + 4);             // row position
  localparam int WSZ = (CPW > 8) ? CPW : 8;
  localparam int HSZ = (RPW > 8) ? RPW : 8;

  // Configuration registers
  logic [7:0] grid_width;
  logic [7:0] grid_height;
  logic [3:0] flip_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width     <= 8'd64;
      grid_height    <= 8'd64;
      flip_threshold <= 4'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_WIDTH:     grid_width     <= cfg_data;
        REG_GRID_HEIGHT:    grid_height    <= cfg_data;
        REG_FLIP_THRESHOLD: flip_threshold <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Effective sizes: zero counts as one, clamp to the store size.
  logic [WSZ-1:0] w_ext;
  logic [WSZ-1:0] w_clamp;
  logic [HSZ-1:0] h_ext;
  logic [HSZ-1:0] h_clamp;
  logic [CPW-1:0] w_eff;
  logic [RPW-1:0] h_eff;

  always_comb begin
    w_ext   = (grid_width == 8'd0) ? WSZ'(1) : WSZ'(grid_width);
    w_clamp = (w_ext > WSZ'(MAX_WIDTH)) ? WSZ'(MAX_WIDTH) : w_ext;
    h_ext   = (grid_height == 8'd0) ? HSZ'(1) : HSZ'(grid_height);
    h_clamp = (h_ext > HSZ'(MAX_HEIGHT)) ? HSZ'(MAX_HEIGHT) : h_ext;
    w_eff   = CPW'(w_clamp);
    h_eff   = RPW'(h_clamp);
  end

  // Handshake and pipeline control
  logic s_fire;
  logic s1_valid;
  logic s1_adv;
  logic store_busy;

  assign s1_adv   = !m_tvalid || m_tready;
  assign s_tready = !store_busy && (!s1_valid || s1_adv);
  assign s_fire   = s_tvalid && s_tready;

  // Input colour: three reads as red, drain stores blue.
  color_t in_color;

  always_comb begin
    in_color = s_tdata[1:0];
    if (in_color == COLOR_THREE) begin
      in_color = COLOR_RED;
    end
    if (s_tuser[0]) begin
      in_color = COLOR_BLUE;
    end
  end

  // Position of the arriving item and the cell it releases
  logic [CPW-1:0] col_pos;
  logic [RPW-1:0] row_pos;
  logic [CPW-1:0] col_pos_next;
  logic [RPW-1:0] row_pos_next;
  logic [CPW-1:0] col_a;
  logic [RPW-1:0] row_a;
  logic [CPW-1:0] col_b;
  logic [RPW-1:0] row_b;
  logic [CPW-1:0] col_inc;
  logic [CPW-1:0] out_col;
  logic [RPW-1:0] out_row;
  logic [RPW-1:0] h_plus1;
  logic           restart;
  logic           have;
  logic           last;
  cell_ctrl_t     ctrl;

  always_comb begin
    h_plus1 = h_eff + RPW'(1);

    // Wrap a column left beyond a narrowed width to the next row.
    col_a = col_pos;
    row_a = row_pos;
    if (col_pos >= w_eff) begin
      col_a = '0;
      row_a = row_pos + RPW'(1);
    end

    // A row beyond the drain end opens a new frame.
    restart = (row_a > h_plus1);
    col_b   = restart ? '0 : col_a;
    row_b   = restart ? '0 : row_a;

    if (col_b != '0) begin
      have    = (row_b != '0);
      out_row = row_b - RPW'(1);
      out_col = col_b - CPW'(1);
    end else begin
      have    = (row_b >= RPW'(2));
      out_row = row_b - RPW'(2);
      out_col = w_eff - CPW'(1);
    end
    if (out_row >= h_eff) begin
      have = 1'b0;
    end
    last = (row_b == h_plus1) && (col_b == '0);

    ctrl.up_ok     = (out_row != '0);
    ctrl.down_ok   = ((out_row + RPW'(1)) < h_eff);
    ctrl.left_ok   = (out_col != '0);
    ctrl.right_ok  = (col_b != '0);
    ctrl.slot      = out_row[1:0];
    ctrl.threshold = flip_threshold;

    // Advance to the next raster position.
    col_inc = col_b + CPW'(1);
    if (last) begin
      col_pos_next = '0;
      row_pos_next = '0;
    end else if (col_inc >= w_eff) begin
      col_pos_next = '0;
      row_pos_next = row_b + RPW'(1);
    end else begin
      col_pos_next = col_inc;
      row_pos_next = row_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (s_fire) begin
      col_pos <= col_pos_next;
      row_pos <= row_pos_next;
    end
  end

  // Ring store: write the arriving cell, read the three columns around
  // the released cell. Port a is the current column, b the cell's own
  // column, c the column to its left.
  logic [CIW-1:0] addr_left;
  ring_word_t     word_right;
  ring_word_t     word_mid;
  ring_word_t     word_left;

  assign addr_left = CIW'(out_col - CPW'(1));

  cag_ring_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .CIW       (CIW)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .busy      (store_busy),
    .wr_en     (s_fire),
    .wr_addr   (CIW'(col_b)),
    .wr_slot   (row_b[1:0]),
    .wr_color  (in_color),
    .rd_en     (s_fire),
    .rd_addr_a (CIW'(col_b)),
    .rd_addr_b (CIW'(out_col)),
    .rd_addr_c (addr_left),
    .word_a    (word_right),
    .word_b    (word_mid),
    .word_c    (word_left)
  );

  // Read stage: holds the item while its column words arrive.
  logic       s1_have;
  logic       s1_last;
  logic       s1_restart;
  cell_ctrl_t s1_ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      s1_have    <= have;
      s1_last    <= last;
      s1_restart <= restart;
      s1_ctrl    <= ctrl;
    end
  end

  color_t rule_color;
  logic   rule_changed;

  cag_cell_rule u_rule (
    .word_left  (word_left),
    .word_mid   (word_mid),
    .word_right (word_right),
    .ctrl       (s1_ctrl),
    .next_color (rule_color),
    .changed    (rule_changed)
  );

  // Change counter: clear on a forced restart before counting, and at the
  // end of the frame after the last result.
  logic [14:0] change_cnt;
  logic [14:0] cnt_base;
  logic [14:0] cnt_new;
  logic        s1_fire;

  assign s1_fire = s1_valid && s1_adv;

  always_comb begin
    cnt_base = s1_restart ? '0 : change_cnt;
    cnt_new  = cnt_base;
    if (s1_have && rule_changed && (cnt_base < COUNT_LIMIT)) begin
      cnt_new = cnt_base + 15'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      change_cnt <= '0;
    end else if (s1_fire) begin
      change_cnt <= s1_last ? '0 : cnt_new;
    end
  end

  // Result register
  color_t      out_color;
  logic        out_changed;
  logic [14:0] out_count;
  logic        out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire && s1_have) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_have) begin
      out_color   <= rule_color;
      out_changed <= rule_changed;
      out_count   <= cnt_new;
      out_last    <= s1_last;
    end
  end

  assign m_tdata = {6'd0, out_count, out_changed, out_color};
  assign m_tlast = out_last;

endmodule

/* design/cag_ring_store.sv */
// ----------------------------------------------------------------------------
// cag_ring_store
// Four-row ring of cell colours held column-wise in two mirrored memories,
// with slot write enables, three registered read ports, same-cycle write
// forwarding and a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module cag_ring_store import cag_pkg::*; #(
  parameter int MAX_WIDTH = 128,
  parameter int CIW       = 7
) (
  input  logic             clk,
  input  logic             rst,
  output logic             busy,
  input  logic             wr_en,
  input  logic [CIW-1:0]   wr_addr,
  input  logic [1:0]       wr_slot,
  input  color_t           wr_color,
  input  logic             rd_en,
  input  logic [CIW-1:0]   rd_addr_a,
  input  logic [CIW-1:0]   rd_addr_b,
  input  logic [CIW-1:0]   rd_addr_c,
  output ring_word_t       word_a,
  output ring_word_t       word_b,
  output ring_word_t       word_c
);

  ring_word_t     mem0 [MAX_WIDTH];
  ring_word_t     mem1 [MAX_WIDTH];
  ring_word_t     rd_a;
  ring_word_t     rd_b;
  ring_word_t     rd_c;
  logic           fwd_a;
  logic           fwd_b;
  logic           fwd_c;
  logic [1:0]     fwd_slot;
  color_t         fwd_color;
  logic           clearing;
  logic [CIW-1:0] clr_addr;

  assign busy = clearing;

  // Sweep every column to zero after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == CIW'(MAX_WIDTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + CIW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem0[clr_addr] <= '0;
      mem1[clr_addr] <= '0;
    end else if (wr_en) begin
      mem0[wr_addr][wr_slot] <= wr_color;
      mem1[wr_addr][wr_slot] <= wr_color;
    end
    if (rd_en) begin
      rd_a <= mem0[rd_addr_a];
      rd_b <= mem0[rd_addr_b];
      rd_c <= mem1[rd_addr_c];
    end
  end

  // Reads return old data; note the write that shares their edge.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_a     <= wr_en && (rd_addr_a == wr_addr);
      fwd_b     <= wr_en && (rd_addr_b == wr_addr);
      fwd_c     <= wr_en && (rd_addr_c == wr_addr);
      fwd_slot  <= wr_slot;
      fwd_color <= wr_color;
    end
  end

  always_comb begin
    word_a = rd_a;
    word_b = rd_b;
    word_c = rd_c;
    if (fwd_a) begin
      word_a[fwd_slot] = fwd_color;
    end
    if (fwd_b) begin
      word_b[fwd_slot] = fwd_color;
    end
    if (fwd_c) begin
      word_c[fwd_slot] = fwd_color;
    end
  end

endmodule

/* design/cag_cell_rule.sv */
// ----------------------------------------------------------------------------
// cag_cell_rule
// Cyclic rule for one cell: count neighbours holding the beating colour
// and flip when the count reaches the threshold.
// ----------------------------------------------------------------------------
module cag_cell_rule import cag_pkg::*; (
  input  ring_word_t word_left,
  input  ring_word_t word_mid,
  input  ring_word_t word_right,
  input  cell_ctrl_t ctrl,
  output color_t     next_color,
  output logic       changed
);

  function automatic color_t beater(input color_t c);
    color_t b;
    case (c)
      COLOR_BLUE:  b = COLOR_RED;
      COLOR_WHITE: b = COLOR_BLUE;
      COLOR_RED:   b = COLOR_WHITE;
      default:     b = COLOR_RED;
    endcase
    return b;
  endfunction

  color_t     old_color;
  color_t     beat;
  logic [1:0] slot_up;
  logic [1:0] slot_dn;
  logic [7:0] hits;
  logic [3:0] count;

  always_comb begin
    old_color = word_mid[ctrl.slot];
    beat      = beater(old_color);
    slot_up   = ctrl.slot - 2'd1;
    slot_dn   = ctrl.slot + 2'd1;

    hits[0] = ctrl.left_ok && ctrl.up_ok && (word_left[slot_up] == beat);
    hits[1] = ctrl.left_ok && (word_left[ctrl.slot] == beat);
    hits[2] = ctrl.left_ok && ctrl.down_ok && (word_left[slot_dn] == beat);
    hits[3] = ctrl.up_ok && (word_mid[slot_up] == beat);
    hits[4] = ctrl.down_ok && (word_mid[slot_dn] == beat);
    hits[5] = ctrl.right_ok && ctrl.up_ok && (word_right[slot_up] == beat);
    hits[6] = ctrl.right_ok && (word_right[ctrl.slot] == beat);
    hits[7] = ctrl.right_ok && ctrl.down_ok && (word_right[slot_dn] == beat);

    count      = 4'($countones(hits));
    next_color = (count >= ctrl.threshold) ? beat : old_color;
    changed    = (next_color != old_color);
  end

endmodule

/* dv/tb_cyclic_automaton_generation.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cyclic_automaton_generation
// Self-checking bench for one generation of the three-colour cyclic automaton.
// ----------------------------------------------------------------------------
// Raster frames go in on the s_ channel. A behavioral copy of the line-buffer
// ring computes each cell's next colour, changed flag, running change count
// and frame end. The results are queued in order, and each m_ transaction is
// checked field by field against the oldest entry. Directed frames cover
// colour three, drain flags on grid cells, threshold extremes, size clamping
// and resizing in mid-frame. Random frames follow. Sender bursts, receiver
// stalls and one long receiver hold-off shape the traffic.
// ----------------------------------------------------------------------------
module tb_cyclic_automaton_generation;
  import cag_pkg::*;

  localparam int          MAX_W         = 128;
  localparam int          MAX_H         = 128;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_ITEMS  = 80;
  localparam int unsigned PRINT_LIMIT   = 40;

  // Index 3 decodes to no register; writes there must change nothing.
  localparam logic [1:0]  REG_UNUSED    = 2'd3;

  typedef struct packed {
    color_t      next_color;
    logic        changed;
    logic [14:0] change_count;
    logic        frame_last;
  } gen_result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_pace_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;
  logic [0:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;

  cyclic_automaton_generation i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Behavioral copy of the block: four-row ring, raster position, frame count
  // and the three registers at their reset values.
  // --------------------------------------------------------------------------
  color_t      ring_rows [4][MAX_W] = '{default: COLOR_BLUE};
  int unsigned width_reg     = 64;
  int unsigned height_reg    = 64;
  int unsigned threshold_reg = 3;
  int unsigned col_pos       = 0;
  int unsigned row_pos       = 0;
  int unsigned frame_changes = 0;

  gen_result_t predicted_cells [$];

  int unsigned mismatch_count = 0;
  int unsigned items_accepted = 0;
  int unsigned cycle_count    = 0;
  int unsigned burst_left     = 0;
  bit          steady_sender  = 1'b0;

  // Hold-off requests from the test thread; the receiver serves them.
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  rx_pace_t    rx_pace       = RX_OPEN;
  int unsigned rx_stretch    = 0;
  int unsigned rx_phase      = 0;

  function automatic int unsigned effective_size(input int unsigned v,
                                                 input int unsigned limit);
    if (v < 1) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  // Colour whose neighbours push a cell of colour c forward.
  function automatic color_t beating_color(input color_t c);
    case (c)
      COLOR_BLUE:  return COLOR_RED;
      COLOR_WHITE: return COLOR_BLUE;
      default:     return COLOR_WHITE;
    endcase
  endfunction

  // Take one accepted input transaction; queue the result it releases, if any.
  function automatic void advance_generation(input color_t color_in, input logic drain);
    int unsigned w, h, orow, ocol, hits;
    int          dr, dc, nr, nc;
    color_t      stored, old, beater, nxt;
    logic        have, last;
    gen_result_t res;
    w = effective_size(width_reg, MAX_W);
    h = effective_size(height_reg, MAX_H);
    stored = (color_in == COLOR_THREE) ? COLOR_RED : color_in;
    if (drain) stored = COLOR_BLUE;

    // A position left stale by a resize wraps or restarts the frame here.
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos > h + 1) begin
      row_pos = 0;
      col_pos = 0;
      frame_changes = 0;
    end
    ring_rows[row_pos % 4][col_pos] = stored;

    // The released cell sits one row up and one column left.
    have = 1'b0;
    orow = 0;
    ocol = 0;
    if (col_pos >= 1) begin
      if (row_pos >= 1) begin
        have = 1'b1;
        orow = row_pos - 1;
        ocol = col_pos - 1;
      end
    end else if (row_pos >= 2) begin
      have = 1'b1;
      orow = row_pos - 2;
      ocol = w - 1;
    end
    if (orow >= h) have = 1'b0;
    last = (row_pos == h + 1) && (col_pos == 0);

    if (have) begin
      old    = ring_rows[orow % 4][ocol];
      beater = beating_color(old);
      hits   = 0;
      for (dr = -1; dr <= 1; dr++) begin
        for (dc = -1; dc <= 1; dc++) begin
          nr = int'(orow) + dr;
          nc = int'(ocol) + dc;
          if (!(dr == 0 && dc == 0) && nr >= 0 && nr < int'(h) && nc >= 0 &&
              nc < int'(w) && ring_rows[nr % 4][nc] == beater)
            hits++;
        end
      end
      nxt = (hits >= threshold_reg) ? beater : old;
      if (nxt != old && frame_changes < 32'(COUNT_LIMIT)) frame_changes++;
      res.next_color   = nxt;
      res.changed      = (nxt != old);
      res.change_count = frame_changes[14:0];
      res.frame_last   = last;
      predicted_cells.push_back(res);
    end

    if (last) begin
      row_pos = 0;
      col_pos = 0;
      frame_changes = 0;
    end else begin
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Result checker: compare every m_ transaction with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    gen_result_t want;
    if (m_tvalid && m_tready) begin
      if (predicted_cells.size() == 0) begin
        report_mismatch("result with no prediction waiting");
      end else begin
        want = predicted_cells.pop_front();
        if (m_tdata[1:0] !== want.next_color)
          report_mismatch($sformatf("next_color %0d, predicted %0d",
                                    m_tdata[1:0], want.next_color));
        if (m_tdata[2] !== want.changed)
          report_mismatch($sformatf("changed %b, predicted %b", m_tdata[2], want.changed));
        if (m_tdata[17:3] !== want.change_count)
          report_mismatch($sformatf("change_count %0d, predicted %0d",
                                    m_tdata[17:3], want.change_count));
        if (m_tlast !== want.frame_last)
          report_mismatch($sformatf("frame_last %b, predicted %b", m_tlast, want.frame_last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver pacing: random stretches of open, coin-flip, sparse and cadenced
  // tready, preempted by long hold-offs when the tests ask for one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      m_tready     <= 1'b0;
      hold_left    <= HOLD_CYCLES - 1;
      holds_served <= holds_served + 1;
    end else begin
      if (rx_stretch == 0) begin
        rx_pace    <= rx_pace_t'($urandom_range(0, 3));
        rx_stretch <= $urandom_range(20, 200);
      end else begin
        rx_stretch <= rx_stretch - 1;
      end
      rx_phase <= rx_phase + 1;
      case (rx_pace)
        RX_OPEN:    m_tready <= 1'b1;
        RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE:  m_tready <= ($urandom_range(0, 3) == 0);
        RX_CADENCE: m_tready <= (rx_phase % 3 == 0);
      endcase
    end
  end

  // Watchdog: end the run if the traffic never drains.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one raster transaction and hold it until accepted. Drop valid for a
  // random gap between bursts unless the sender is steady.
  task automatic send_cell(input color_t color_in, input logic drain);
    int unsigned gap;
    cfg_valid <= 1'b0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = 0;
      if (!steady_sender && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, color_in};
    s_tuser  <= drain;
    do @(posedge clk); while (!s_tready);
    items_accepted++;
    advance_generation(color_in, drain);
  endtask

  // Drop valid, wait for every predicted result, then let the read stage
  // empty out so no transaction is left in flight.
  task automatic settle_block();
    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (predicted_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Valid stays high after the handshake; the next helper that advances
  // time drops it, so back-to-back writes never toggle it within one step.
  task automatic write_register(input logic [1:0] index, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_GRID_WIDTH:     width_reg     = 32'(value);
      REG_GRID_HEIGHT:    height_reg    = 32'(value);
      REG_FLIP_THRESHOLD: threshold_reg = 32'(value[3:0]);
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned w, input int unsigned h,
                           input int unsigned thr);
    settle_block();
    write_register(REG_GRID_WIDTH, w[7:0]);
    write_register(REG_GRID_HEIGHT, h[7:0]);
    // Random upper nibble: only the low four bits reach the register.
    write_register(REG_FLIP_THRESHOLD, {4'($urandom_range(0, 15)), thr[3:0]});
  endtask

  // One well-formed frame of random colours at the current sizes. A few grid
  // cells carry the drain flag and a few drain slots lack it.
  task automatic send_frame();
    int unsigned w, h, k;
    w = effective_size(width_reg, MAX_W);
    h = effective_size(height_reg, MAX_H);
    for (k = 0; k < w * h; k++)
      send_cell(color_t'($urandom_range(0, 3)), $urandom_range(0, 15) == 0);
    for (k = 0; k <= w; k++)
      send_cell(color_t'($urandom_range(0, 3)), $urandom_range(0, 7) != 0);
  endtask

  // Advance with drain transactions until the block sits at a frame start.
  task automatic flush_frame();
    while (col_pos != 0 || row_pos != 0)
      send_cell(color_t'($urandom_range(0, 3)), 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset sizes 64 x 64 and threshold 3, no register written yet: the first
  // rows of a frame, then shrink to one cell to close it.
  task automatic test_reset_defaults();
    int unsigned k;
    for (k = 0; k < 80; k++) send_cell(color_t'($urandom_range(0, 3)), 1'b0);
    configure(1, 1, 3);
    flush_frame();
  endtask

  // 3 x 3 frames with chosen colours: every colour code, colour three,
  // a drain flag on a grid cell, threshold zero and the full threshold of 8.
  task automatic test_directed_cases();
    color_t      mixed  [9];
    logic        flags  [9];
    color_t      circled[9];
    int unsigned k;
    mixed   = '{COLOR_BLUE, COLOR_WHITE, COLOR_RED, COLOR_THREE, COLOR_RED,
                COLOR_WHITE, COLOR_BLUE, COLOR_THREE, COLOR_WHITE};
    flags   = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
    circled = '{COLOR_RED, COLOR_RED, COLOR_RED, COLOR_RED, COLOR_BLUE,
                COLOR_RED, COLOR_RED, COLOR_RED, COLOR_RED};
    configure(3, 3, 0);
    // Write the undecoded index; nothing may change.
    write_register(REG_UNUSED, 8'h01);
    for (k = 0; k < 9; k++) send_cell(mixed[k], flags[k]);
    send_cell(COLOR_THREE, 1'b1);
    send_cell(COLOR_WHITE, 1'b1);
    send_cell(COLOR_BLUE, 1'b1);
    send_cell(COLOR_RED, 1'b1);
    // Blue centre ringed by red: only the centre reaches eight beaters.
    configure(3, 3, 8);
    for (k = 0; k < 9; k++) send_cell(circled[k], 1'b0);
    for (k = 0; k < 4; k++) send_cell(COLOR_BLUE, 1'b1);
  endtask

  // Zero sizes count as one, oversize values clamp to 128.
  task automatic test_size_extremes();
    configure(0, 0, 0);
    send_frame();
    send_frame();
    configure(255, 1, 2);
    send_frame();
    configure(1, 200, 1);
    send_frame();
  endtask

  // Thresholds from always-change to never-change on a 3 x 3 grid.
  task automatic test_thresholds();
    int unsigned levels[6];
    int unsigned k;
    levels = '{0, 1, 2, 8, 9, 15};
    for (k = 0; k < 6; k++) begin
      configure(3, 3, levels[k]);
      send_frame();
    end
  endtask

  // Shrink the width with the column beyond it, then the height, both while
  // the block is idle in mid-frame.
  task automatic test_midframe_resize();
    configure(5, 4, 2);
    repeat (14) send_cell(color_t'($urandom_range(0, 3)), 1'b0);
    settle_block();
    write_register(REG_GRID_WIDTH, 8'd3);
    repeat (8) send_cell(color_t'($urandom_range(0, 3)), 1'b0);
    settle_block();
    write_register(REG_GRID_HEIGHT, 8'd1);
    repeat (5) send_cell(color_t'($urandom_range(0, 3)), 1'b0);
    flush_frame();
  endtask

  // Hold the receiver off for a long stretch while the sender keeps
  // offering back to back, so the pipeline fills and s_tready drops.
  task automatic test_backpressure();
    configure(8, 6, 2);
    steady_sender = 1'b1;
    hold_requests <= hold_requests + 1;
    send_frame();
    steady_sender = 1'b0;
  endtask

  // Mostly well-formed frames at random small sizes and thresholds; now and
  // then a run of noise that may leave the position in mid-frame.
  task automatic test_random_frames();
    int unsigned start_count, w, h, thr, k, noise_len;
    start_count = items_accepted;
    while (items_accepted - start_count < RANDOM_ITEMS) begin
      w   = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
      h   = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 10) : $urandom_range(1, 8);
      thr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
      configure(w, h, thr);
      steady_sender = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 5) == 0) begin
          noise_len = $urandom_range(1, 2 * w * h);
          for (k = 0; k < noise_len; k++)
            send_cell(color_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 1) == 0) flush_frame();
        end else begin
          send_frame();
        end
      end
    end
    steady_sender = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_cases();
    test_size_extremes();
    test_thresholds();
    test_midframe_resize();
    test_backpressure();
    test_random_frames();

    settle_block();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* cyclic_automaton_generation.f */
design/cag_pkg.sv
design/cag_ring_store.sv
design/cag_cell_rule.sv
design/cyclic_automaton_generation.sv
dv/tb_cyclic_automaton_generation.sv
